[sv/sbpf_pkg.sv]
// ----------------------------------------------------------------------------
// sbpf_pkg
// Types and constants shared by the servo bus packet framer modules.
// ----------------------------------------------------------------------------
package sbpf_pkg;

   localparam logic [7:0] HDR_BYTE  = 8'hFF;
   localparam logic [7:0] LEN_EXTRA = 8'd2;

   // job queue between front and back
   localparam int JOBQ_AW    = 2;
   localparam int JOBQ_DEPTH = 1 << JOBQ_AW;

   typedef struct packed {
      logic [7:0] target_id;
      logic [7:0] instruction;
      logic [7:0] param_count;
      logic [7:0] param_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       run_last;
      logic       packet_end;
   } rsp_type;

   // one classified item: which bytes to send and their values
   typedef struct packed {
      logic       hdr;
      logic       has_par;
      logic       has_cks;
      logic [7:0] id;
      logic [7:0] len;
      logic [7:0] ins;
      logic [7:0] par;
      logic [7:0] cks;
   } job_type;

endpackage

[sv/sbpf_front.sv]
// ----------------------------------------------------------------------------
// sbpf_front
// Classifies each input beat as packet start or continuation, keeps the
// packet state and the running checksum, and builds one job per beat.
// ----------------------------------------------------------------------------
module sbpf_front (
   input  logic             clock,
   input  logic             reset,
   input  sbpf_pkg::req_type req_data,
   input  logic             req_accept,
   output sbpf_pkg::job_type job
);

   logic       in_packet_ff, in_packet_in;
   logic [7:0] params_left_ff, params_left_in;
   logic [7:0] running_sum_ff, running_sum_in;

   logic       first;
   logic       has_par;
   logic [7:0] len;
   logic [7:0] base_sum;
   logic [7:0] sum;
   logic [7:0] left;
   logic       cks_now;

   always_comb begin
      first    = !in_packet_ff;
      len      = req_data.param_count + sbpf_pkg::LEN_EXTRA;
      base_sum = req_data.target_id + len + req_data.instruction;
      if (first) begin
         has_par = (req_data.param_count != 8'd0);
         sum     = has_par ? base_sum + req_data.param_byte : base_sum;
         left    = req_data.param_count - 8'd1;
         cks_now = !has_par || (left == 8'd0);
      end else begin
         has_par = 1'b1;
         sum     = running_sum_ff + req_data.param_byte;
         left    = params_left_ff - 8'd1;
         cks_now = (left == 8'd0);
      end

      job.hdr     = first;
      job.has_par = has_par;
      job.has_cks = cks_now;
      job.id      = req_data.target_id;
      job.len     = len;
      job.ins     = req_data.instruction;
      job.par     = req_data.param_byte;
      job.cks     = ~sum;

      in_packet_in   = in_packet_ff;
      params_left_in = params_left_ff;
      running_sum_in = running_sum_ff;
      if (req_accept) begin
         running_sum_in = sum;
         if (cks_now) begin
            in_packet_in   = 1'b0;
            params_left_in = 8'd0;
         end else begin
            in_packet_in   = 1'b1;
            params_left_in = left;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff   <= 1'b0;
         params_left_ff <= 8'd0;
         running_sum_ff <= 8'd0;
      end else begin
         in_packet_ff   <= in_packet_in;
         params_left_ff <= params_left_in;
         running_sum_ff <= running_sum_in;
      end
   end

endmodule

[sv/sbpf_job_q.sv]
// ----------------------------------------------------------------------------
// sbpf_job_q
// Short job queue between the front and the back of the framer.
// ----------------------------------------------------------------------------
module sbpf_job_q (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sbpf_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output sbpf_pkg::job_type head_job,
   output logic              head_valid
);

   sbpf_pkg::job_type                mem_ff [sbpf_pkg::JOBQ_DEPTH];
   logic [sbpf_pkg::JOBQ_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [sbpf_pkg::JOBQ_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [sbpf_pkg::JOBQ_AW:0]       count_ff, count_in;
   logic                             do_push, do_pop;

   always_comb begin
      full       = (count_ff == (sbpf_pkg::JOBQ_AW+1)'(sbpf_pkg::JOBQ_DEPTH));
      head_valid = (count_ff != '0);
      head_job   = mem_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[sv/sbpf_back.sv]
// ----------------------------------------------------------------------------
// sbpf_back
// Walks the head job's bytes one per cycle into the free output register.
// ----------------------------------------------------------------------------
module sbpf_back (
   input  logic              clock,
   input  logic              reset,
   input  sbpf_pkg::job_type job,
   input  logic              job_valid,
   output logic              job_pop,
   output sbpf_pkg::rsp_type rsp_data,
   output logic              rsp_empty,
   input  logic              rsp_pop
);

   typedef enum logic [2:0] {
      ST_FF1,
      ST_FF2,
      ST_ID,
      ST_LEN,
      ST_INS,
      ST_PAR,
      ST_CKS
   } step_type;

   step_type          step_ff, step_in;
   logic              started_ff, started_in;
   logic              out_valid_ff, out_valid_in;
   sbpf_pkg::rsp_type rsp_ff, rsp_in;

   step_type   cur;
   step_type   nxt;
   logic [7:0] cur_byte;
   logic       last;
   logic       advance;

   always_comb begin
      cur = started_ff ? step_ff : (job.hdr ? ST_FF1 : ST_PAR);
      cur_byte = sbpf_pkg::HDR_BYTE;
      last     = 1'b0;
      nxt      = ST_CKS;
      case (cur)
         ST_FF1: begin
            cur_byte = sbpf_pkg::HDR_BYTE;
            nxt      = ST_FF2;
         end
         ST_FF2: begin
            cur_byte = sbpf_pkg::HDR_BYTE;
            nxt      = ST_ID;
         end
         ST_ID: begin
            cur_byte = job.id;
            nxt      = ST_LEN;
         end
         ST_LEN: begin
            cur_byte = job.len;
            nxt      = ST_INS;
         end
         ST_INS: begin
            cur_byte = job.ins;
            nxt      = job.has_par ? ST_PAR : ST_CKS;
         end
         ST_PAR: begin
            cur_byte = job.par;
            last     = !job.has_cks;
            nxt      = ST_CKS;
         end
         ST_CKS: begin
            cur_byte = job.cks;
            last     = 1'b1;
            nxt      = ST_CKS;
         end
         default: begin
            cur_byte = sbpf_pkg::HDR_BYTE;
            last     = 1'b1;
            nxt      = ST_CKS;
         end
      endcase

      // output register takes a new beat when free or being drained
      advance = job_valid && (!out_valid_ff || rsp_pop);
      job_pop = advance && last;

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end

      started_in = started_ff;
      step_in    = step_ff;
      if (advance) begin
         started_in = !last;
         step_in    = nxt;
      end

      rsp_in = rsp_ff;
      if (advance) begin
         rsp_in.tx_byte    = cur_byte;
         rsp_in.run_last   = last;
         rsp_in.packet_end = (cur == ST_CKS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_FF1;
         started_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         started_ff   <= started_in;
         out_valid_ff <= out_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_empty = !out_valid_ff;

endmodule

[sv/servo_bus_packet_framer.sv]
// ----------------------------------------------------------------------------
// servo_bus_packet_framer
// Frames servo bus command packets: header, id, length, instruction,
// parameter bytes and inverted checksum, one byte per result beat.
//
//   channel   ports                         beat
//   req       req_push, req_full, req_data  one parameter byte (+ header on start)
//   rsp       rsp_pop, rsp_empty, rsp_data  one byte on the wire
//
// The result side sends one byte per cycle while rsp_pop drains it. A packet's
// first item also sends the header, id, length and instruction bytes; any item
// may end with the checksum. The front classifies one item per cycle into a
// 4-deep job queue while it is not full, so items are taken while earlier
// bytes still drain. Synchronous reset empties the queue and the output register.
// ----------------------------------------------------------------------------
module servo_bus_packet_framer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  sbpf_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output sbpf_pkg::rsp_type rsp_data
);

   sbpf_pkg::job_type front_job;
   sbpf_pkg::job_type head_job;
   logic              head_valid;
   logic              head_pop;
   logic              req_accept;

   assign req_accept = req_push && !req_full;

   sbpf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .req_accept (req_accept),
      .job        (front_job)
   );

   sbpf_job_q u_job_q (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .push_job   (front_job),
      .full       (req_full),
      .pop        (head_pop),
      .head_job   (head_job),
      .head_valid (head_valid)
   );

   sbpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (head_job),
      .job_valid (head_valid),
      .job_pop   (head_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule
